@@ rtl/bilinear_image_scaler_top_macros.svh @@
// Assertion macros for the bilinear image scaler.
// Included by the top level; no other dependencies.
`ifndef BILINEAR_IMAGE_SCALER_TOP_MACROS_SVH
`define BILINEAR_IMAGE_SCALER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define BIS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bis assertion failed");
`define BIS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bis assertion failed");
`else
`define BIS_ASSERT_SAME(lbl, ante, cons)
`define BIS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ rtl/bis_pkg.sv @@
// Shared types and constants of the bilinear image scaler.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bis_pkg;
  localparam int SRCW_W    = 9;
  localparam int OUTW_W    = 11;
  localparam int SCALE_W   = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;
  localparam int CH_W      = 8;
  localparam int PIX_W     = 24;
  localparam int MUL_W     = 16;
  localparam int PROD_W    = 32;
  localparam int FRAC_W    = 8;
  localparam int TX_W      = PROD_W - FRAC_W;
  localparam int WGT_W     = 17;
  localparam int ACC_W     = 24;
  localparam logic [CH_W-1:0] WHITE_LEVEL = 8'd255;

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_SCALE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FLIP_ROWS  = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LTOT, ST_LWR, ST_MX, ST_MY, ST_WIN, ST_BASE,
    ST_WGT, ST_READ, ST_DRAIN, ST_OUT
  } state_t;
endpackage
`default_nettype wire

@@ rtl/bis_frame_store.sv @@
// Single-port frame store with registered read data.
// Uses bis_pkg for the pixel width.
`timescale 1ns / 1ps
`default_nettype none
module bis_frame_store #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [AW-1:0]             addr,
  input  wire logic [bis_pkg::PIX_W-1:0] wdata,
  output logic      [bis_pkg::PIX_W-1:0] rdata
);
  logic [bis_pkg::PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

@@ rtl/bilinear_image_scaler_top.sv @@
// Top level of the bilinear image scaler: sequencer, shared multiplier, blend.
// Depends on bis_pkg, bis_frame_store and bilinear_image_scaler_top_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//   Commands enter on start/in_* and transfer at an edge with start high and
//   busy low. in_opcode 0 loads the next source pixel (row-major), 1 requests
//   the next output pixel (row-major, rows reversed when flip_rows is set).
//   A request yields one result on out_* with out_valid high for exactly one
//   cycle; out_frame_last marks the final pixel of the output frame. Loads
//   give no result. The receiver cannot stall, so a result never waits.
//   Busy: busy stays high from the transfer until the command is done. A
//   request strobes its result in the cycle busy drops; when the 2x2 window
//   does not fit, the pixel is white and the weights and reads are skipped.
//   One shared 16x16 multiplier forms the image size for loads and, for a
//   request, two coordinate products, the row base address and four weights,
//   one per cycle; the single-port frame store gives four reads, one per cycle.
//   Configuration: cfg_we writes register cfg_index with cfg_wdata at once;
//   write only while busy is low. Unknown indexes are dropped.
//   Reset (rst_n low, synchronous) clears the sequencer, counters and
//   configuration registers to their defaults; the frame store is not
//   cleared and must be loaded before it is read.
module bilinear_image_scaler_top #(
  parameter int MAX_SRC_WIDTH  = 256,
  parameter int MAX_SRC_HEIGHT = 256,
  parameter int MAX_OUT_DIM    = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_opcode,
  input  wire logic [bis_pkg::CH_W-1:0]      in_red_in,
  input  wire logic [bis_pkg::CH_W-1:0]      in_green_in,
  input  wire logic [bis_pkg::CH_W-1:0]      in_blue_in,
  output logic                               out_valid,
  output logic [bis_pkg::CH_W-1:0]           out_red_out,
  output logic [bis_pkg::CH_W-1:0]           out_green_out,
  output logic [bis_pkg::CH_W-1:0]           out_blue_out,
  output logic                               out_frame_last,
  input  wire logic                          cfg_we,
  input  wire logic [bis_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bis_pkg::CFG_DAT_W-1:0] cfg_wdata
);
  localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int WW    = $clog2(MAX_SRC_WIDTH + 1);
  localparam int HW    = $clog2(MAX_SRC_HEIGHT + 1);
  localparam int OW    = $clog2(MAX_OUT_DIM + 1);
  localparam int CW    = $clog2(MAX_OUT_DIM);
  localparam int RW    = $clog2(MAX_SRC_HEIGHT);
  localparam int CLW   = $clog2(MAX_SRC_WIDTH);

  // Configuration registers.
  logic [bis_pkg::SRCW_W-1:0]  src_width_r, src_height_r;
  logic [bis_pkg::OUTW_W-1:0]  out_width_r, out_height_r;
  logic [bis_pkg::SCALE_W-1:0] inv_scale_r;
  logic                        flip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= bis_pkg::SRCW_W'(1);
      src_height_r <= bis_pkg::SRCW_W'(1);
      out_width_r  <= bis_pkg::OUTW_W'(1);
      out_height_r <= bis_pkg::OUTW_W'(1);
      inv_scale_r  <= bis_pkg::SCALE_W'(256);
      flip_r       <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bis_pkg::CFG_SRC_WIDTH:  src_width_r  <= cfg_wdata[bis_pkg::SRCW_W-1:0];
        bis_pkg::CFG_SRC_HEIGHT: src_height_r <= cfg_wdata[bis_pkg::SRCW_W-1:0];
        bis_pkg::CFG_OUT_WIDTH:  out_width_r  <= cfg_wdata[bis_pkg::OUTW_W-1:0];
        bis_pkg::CFG_OUT_HEIGHT: out_height_r <= cfg_wdata[bis_pkg::OUTW_W-1:0];
        bis_pkg::CFG_INV_SCALE:  inv_scale_r  <= cfg_wdata[bis_pkg::SCALE_W-1:0];
        bis_pkg::CFG_FLIP_ROWS:  flip_r       <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Clamp the sizes to the store and the counter range.
  logic [WW-1:0] w_cl;
  logic [HW-1:0] h_cl;
  logic [OW-1:0] ow_cl, oh_cl;

  always_comb begin
    if (src_width_r == '0) w_cl = WW'(1);
    else if (32'(src_width_r) > 32'(MAX_SRC_WIDTH)) w_cl = WW'(MAX_SRC_WIDTH);
    else w_cl = WW'(src_width_r);
    if (src_height_r == '0) h_cl = HW'(1);
    else if (32'(src_height_r) > 32'(MAX_SRC_HEIGHT)) h_cl = HW'(MAX_SRC_HEIGHT);
    else h_cl = HW'(src_height_r);
    if (out_width_r == '0) ow_cl = OW'(1);
    else if (32'(out_width_r) > 32'(MAX_OUT_DIM)) ow_cl = OW'(MAX_OUT_DIM);
    else ow_cl = OW'(out_width_r);
    if (out_height_r == '0) oh_cl = OW'(1);
    else if (32'(out_height_r) > 32'(MAX_OUT_DIM)) oh_cl = OW'(MAX_OUT_DIM);
    else oh_cl = OW'(out_height_r);
  end

  bis_pkg::state_t state_r, state_nxt;
  logic [1:0]      k_r;

  // Datapath registers.
  logic [bis_pkg::PIX_W-1:0]  pix_r;
  logic [AW-1:0]              load_r;
  logic [CW-1:0]              row_r, col_r;
  logic [bis_pkg::PROD_W-1:0] prod_r, fx_r;
  logic [bis_pkg::FRAC_W-1:0] u_r, v_r;
  logic [RW-1:0]              r0_r;
  logic [CLW-1:0]             c0_r;
  logic                       white_r;
  logic [AW-1:0]              base_r;
  logic [bis_pkg::WGT_W-1:0]  wgt_r [4];
  logic                       rd_vld_r;
  logic [1:0]                 rd_k_r;
  logic [bis_pkg::ACC_W-1:0]  acc_r [3];

  // Counters clamped before use, after a possible register rewrite.
  logic [CW-1:0] row_cl, col_cl, x_pos;
  always_comb begin
    row_cl = (32'(row_r) >= 32'(oh_cl)) ? '0 : row_r;
    col_cl = (32'(col_r) >= 32'(ow_cl)) ? '0 : col_r;
    x_pos  = flip_r ? CW'(32'(oh_cl) - 32'd1 - 32'(row_cl)) : row_cl;
  end

  // Window decision from the two coordinate products.
  logic [bis_pkg::TX_W-1:0] tx, ty;
  logic                     fit_main, fit_alt;
  always_comb begin
    tx = fx_r[bis_pkg::PROD_W-1:bis_pkg::FRAC_W];
    ty = prod_r[bis_pkg::PROD_W-1:bis_pkg::FRAC_W];
    fit_main = (32'(tx) + 32'd1 <= 32'(h_cl) - 32'd1) &&
               (32'(ty) + 32'd1 <= 32'(w_cl) - 32'd1);
    fit_alt  = (tx != '0) && (ty != '0) &&
               (32'(tx) <= 32'(h_cl) - 32'd1) && (32'(ty) <= 32'(w_cl) - 32'd1);
  end

  // Load position handling.
  logic [AW:0]   total;
  logic [AW-1:0] load_pos;
  logic [AW:0]   load_next;
  always_comb begin
    total     = prod_r[AW:0];
    load_pos  = ({1'b0, load_r} >= total) ? '0 : load_r;
    load_next = {1'b0, load_pos} + (AW+1)'(1);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bis_pkg::ST_IDLE:  if (start) state_nxt = in_opcode ? bis_pkg::ST_MX : bis_pkg::ST_LTOT;
      bis_pkg::ST_LTOT:  state_nxt = bis_pkg::ST_LWR;
      bis_pkg::ST_LWR:   state_nxt = bis_pkg::ST_IDLE;
      bis_pkg::ST_MX:    state_nxt = bis_pkg::ST_MY;
      bis_pkg::ST_MY:    state_nxt = bis_pkg::ST_WIN;
      bis_pkg::ST_WIN:   state_nxt = (fit_main || fit_alt) ? bis_pkg::ST_BASE : bis_pkg::ST_OUT;
      bis_pkg::ST_BASE:  state_nxt = bis_pkg::ST_WGT;
      bis_pkg::ST_WGT:   if (k_r == 2'd3) state_nxt = bis_pkg::ST_READ;
      bis_pkg::ST_READ:  if (k_r == 2'd3) state_nxt = bis_pkg::ST_DRAIN;
      bis_pkg::ST_DRAIN: state_nxt = bis_pkg::ST_OUT;
      bis_pkg::ST_OUT:   state_nxt = bis_pkg::ST_IDLE;
      default:           state_nxt = bis_pkg::ST_IDLE;
    endcase
  end

  // Control outputs: multiplier operands and frame store port.
  logic [bis_pkg::MUL_W-1:0] mul_a, mul_b;
  logic                      mem_we;
  logic [AW-1:0]             mem_addr;
  logic [AW:0]               rd_addr;
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mem_we = 1'b0;
    rd_addr = (AW+1)'(base_r) + (k_r[0] ? (AW+1)'(w_cl) : '0) +
              (AW+1)'(c0_r) + (AW+1)'(k_r[1]);
    mem_addr = rd_addr[AW-1:0];
    unique case (state_r)
      bis_pkg::ST_LTOT: begin
        mul_a = bis_pkg::MUL_W'(w_cl);
        mul_b = bis_pkg::MUL_W'(h_cl);
      end
      bis_pkg::ST_LWR: begin
        mem_we   = 1'b1;
        mem_addr = load_pos;
      end
      bis_pkg::ST_MX: begin
        mul_a = bis_pkg::MUL_W'(x_pos);
        mul_b = inv_scale_r;
      end
      bis_pkg::ST_MY: begin
        mul_a = bis_pkg::MUL_W'(col_r);
        mul_b = inv_scale_r;
      end
      bis_pkg::ST_BASE: begin
        mul_a = bis_pkg::MUL_W'(r0_r);
        mul_b = bis_pkg::MUL_W'(w_cl);
      end
      bis_pkg::ST_WGT: begin
        mul_a = k_r[0] ? bis_pkg::MUL_W'(u_r) : bis_pkg::MUL_W'(9'd256 - {1'b0, u_r});
        mul_b = k_r[1] ? bis_pkg::MUL_W'(v_r) : bis_pkg::MUL_W'(9'd256 - {1'b0, v_r});
      end
      default: ;
    endcase
  end

  logic [bis_pkg::PIX_W-1:0] mem_q;
  bis_frame_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (pix_r),
    .rdata (mem_q)
  );

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= bis_pkg::ST_IDLE;
      k_r       <= '0;
      load_r    <= '0;
      row_r     <= '0;
      col_r     <= '0;
      rd_vld_r  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_vld_r  <= (state_r == bis_pkg::ST_READ);
      out_valid <= (state_r == bis_pkg::ST_OUT);
      if (state_r == bis_pkg::ST_BASE) k_r <= '0;
      else if (state_r == bis_pkg::ST_WGT || state_r == bis_pkg::ST_READ) k_r <= k_r + 2'd1;
      if (state_r == bis_pkg::ST_LWR) begin
        load_r <= (load_next >= total) ? '0 : load_next[AW-1:0];
      end
      // Store the clamped counters, then advance them after the result.
      if (state_r == bis_pkg::ST_MX) begin
        row_r <= row_cl;
        col_r <= col_cl;
      end
      if (state_r == bis_pkg::ST_OUT) begin
        if (32'(col_r) + 32'd1 >= 32'(ow_cl)) begin
          col_r <= '0;
          row_r <= (32'(row_r) + 32'd1 >= 32'(oh_cl)) ? '0 : CW'(32'(row_r) + 32'd1);
        end else begin
          col_r <= CW'(32'(col_r) + 32'd1);
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    prod_r <= bis_pkg::PROD_W'(mul_a * mul_b);
    rd_k_r <= k_r;
    if (state_r == bis_pkg::ST_IDLE) pix_r <= {in_red_in, in_green_in, in_blue_in};
    if (state_r == bis_pkg::ST_MY) fx_r <= prod_r;
    if (state_r == bis_pkg::ST_WIN) begin
      u_r     <= fx_r[bis_pkg::FRAC_W-1:0];
      v_r     <= prod_r[bis_pkg::FRAC_W-1:0];
      white_r <= !(fit_main || fit_alt);
      // Shift the window back one at the last row or column.
      r0_r <= fit_main ? RW'(tx) : RW'(tx - bis_pkg::TX_W'(1));
      c0_r <= fit_main ? CLW'(ty) : CLW'(ty - bis_pkg::TX_W'(1));
    end
    if (state_r == bis_pkg::ST_WGT) begin
      if (k_r == 2'd0) base_r <= prod_r[AW-1:0];
      else wgt_r[2'(k_r - 2'd1)] <= prod_r[bis_pkg::WGT_W-1:0];
    end
    if (state_r == bis_pkg::ST_READ && k_r == 2'd0) wgt_r[3] <= prod_r[bis_pkg::WGT_W-1:0];
    if (state_r == bis_pkg::ST_BASE) begin
      for (int c = 0; c < 3; c++) acc_r[c] <= '0;
    end else if (rd_vld_r) begin
      for (int c = 0; c < 3; c++) begin
        acc_r[c] <= acc_r[c] + bis_pkg::ACC_W'(wgt_r[rd_k_r] *
                    mem_q[(2-c)*bis_pkg::CH_W +: bis_pkg::CH_W]);
      end
    end
    if (state_r == bis_pkg::ST_OUT) begin
      out_red_out    <= white_r ? bis_pkg::WHITE_LEVEL : acc_r[0][bis_pkg::ACC_W-1 -: 8];
      out_green_out  <= white_r ? bis_pkg::WHITE_LEVEL : acc_r[1][bis_pkg::ACC_W-1 -: 8];
      out_blue_out   <= white_r ? bis_pkg::WHITE_LEVEL : acc_r[2][bis_pkg::ACC_W-1 -: 8];
      out_frame_last <= (32'(row_r) == 32'(oh_cl) - 32'd1) &&
                        (32'(col_r) == 32'(ow_cl) - 32'd1);
    end
  end

  assign busy = (state_r != bis_pkg::ST_IDLE);

`include "bilinear_image_scaler_top_macros.svh"
  `BIS_ASSERT_SAME(a_strobe_idle, out_valid, state_r == bis_pkg::ST_IDLE)
  `BIS_ASSERT_NEXT(a_req_busy, start && !busy && in_opcode, state_r == bis_pkg::ST_MX)
  `BIS_ASSERT_SAME(a_strobe_src, out_valid, $past(state_r) == bis_pkg::ST_OUT)
endmodule
`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for bilinear_image_scaler_top: directed table, then random phases.
// Depends on bis_pkg and the scaler RTL; a built-in predictor computes every expected pixel.
`timescale 1ns / 1ps
module tb;
  localparam logic [bis_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [bis_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;
  localparam int TARGET_ITEMS = 1300;
  localparam int CALM_ITEMS   = 1150;

  typedef enum logic [1:0] { ROW_LOAD, ROW_REQ, ROW_CFG } row_kind_t;

  typedef struct packed {
    logic [bis_pkg::CH_W-1:0] red;
    logic [bis_pkg::CH_W-1:0] green;
    logic [bis_pkg::CH_W-1:0] blue;
    logic                     last;
  } pixel_t;

  typedef struct {
    row_kind_t                     kind;
    logic [bis_pkg::CH_W-1:0]      r, g, b;
    logic [bis_pkg::CFG_IDX_W-1:0] idx;
    logic [bis_pkg::CFG_DAT_W-1:0] data;
    bit                            typed;
    pixel_t                        want;
  } row_t;

  logic clk, rst_n, start, busy, in_opcode;
  logic [bis_pkg::CH_W-1:0] in_red_in, in_green_in, in_blue_in;
  logic out_valid, out_frame_last;
  logic [bis_pkg::CH_W-1:0] out_red_out, out_green_out, out_blue_out;
  logic cfg_we;
  logic [bis_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [bis_pkg::CFG_DAT_W-1:0] cfg_wdata;

  bilinear_image_scaler_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_red_in(in_red_in), .in_green_in(in_green_in),
    .in_blue_in(in_blue_in), .out_valid(out_valid), .out_red_out(out_red_out),
    .out_green_out(out_green_out), .out_blue_out(out_blue_out),
    .out_frame_last(out_frame_last), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Shadow copy of the block's state and registers.
  logic [bis_pkg::PIX_W-1:0] shadow_store [65536];
  int unsigned load_ptr, row_ctr, col_ctr;
  int unsigned reg_src_w, reg_src_h, reg_out_w, reg_out_h, reg_inv, reg_flip;

  pixel_t pending_pixels[$];
  int mismatches;
  int item_count;

  function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [bis_pkg::PIX_W-1:0] read_store(int unsigned r, int unsigned c,
                                                           int unsigned w);
    int unsigned a;
    a = r * w + c;
    return (a < 65536) ? shadow_store[a] : '0;
  endfunction

  task automatic shadow_write_reg(logic [bis_pkg::CFG_IDX_W-1:0] idx,
                                  logic [bis_pkg::CFG_DAT_W-1:0] d);
    case (idx)
      bis_pkg::CFG_SRC_WIDTH:  reg_src_w = 32'(d & 16'h01FF);
      bis_pkg::CFG_SRC_HEIGHT: reg_src_h = 32'(d & 16'h01FF);
      bis_pkg::CFG_OUT_WIDTH:  reg_out_w = 32'(d & 16'h07FF);
      bis_pkg::CFG_OUT_HEIGHT: reg_out_h = 32'(d & 16'h07FF);
      bis_pkg::CFG_INV_SCALE:  reg_inv   = 32'(d);
      bis_pkg::CFG_FLIP_ROWS:  reg_flip  = 32'(d & 16'h0001);
      default: ;
    endcase
  endtask

  task automatic store_source_pixel(logic [bis_pkg::CH_W-1:0] r, g, b);
    int unsigned total;
    total = clamp_size(reg_src_w, 256) * clamp_size(reg_src_h, 256);
    if (load_ptr >= total) load_ptr = 0;
    shadow_store[load_ptr] = {r, g, b};
    load_ptr++;
    if (load_ptr >= total) load_ptr = 0;
  endtask

  function automatic pixel_t blend_next_pixel();
    int unsigned w, h, ow, oh, x, y, fx, fy, tx, ty, u, v, r0, c0, s;
    int unsigned w00, w10, w01, w11;
    logic [bis_pkg::PIX_W-1:0] p00, p10, p01, p11;
    bit fits;
    pixel_t px;
    w = clamp_size(reg_src_w, 256);
    h = clamp_size(reg_src_h, 256);
    ow = clamp_size(reg_out_w, 1024);
    oh = clamp_size(reg_out_h, 1024);
    if (row_ctr >= oh) row_ctr = 0;
    if (col_ctr >= ow) col_ctr = 0;
    x = reg_flip ? (oh - 1 - row_ctr) : row_ctr;
    y = col_ctr;
    fx = x * reg_inv;
    fy = y * reg_inv;
    tx = fx >> 8; u = fx & 255;
    ty = fy >> 8; v = fy & 255;
    fits = 1; r0 = tx; c0 = ty;
    // Shift the window back at the last row or column; white if even that misses.
    if (!(tx + 1 <= h - 1 && ty + 1 <= w - 1)) begin
      if (tx >= 1 && ty >= 1 && tx <= h - 1 && ty <= w - 1) begin
        r0 = tx - 1; c0 = ty - 1;
      end else begin
        fits = 0;
      end
    end
    px.red = bis_pkg::WHITE_LEVEL;
    px.green = bis_pkg::WHITE_LEVEL;
    px.blue = bis_pkg::WHITE_LEVEL;
    if (fits) begin
      p00 = read_store(r0, c0, w);
      p10 = read_store(r0 + 1, c0, w);
      p01 = read_store(r0, c0 + 1, w);
      p11 = read_store(r0 + 1, c0 + 1, w);
      w00 = (256 - u) * (256 - v);
      w10 = u * (256 - v);
      w01 = (256 - u) * v;
      w11 = u * v;
      for (int k = 0; k < 3; k++) begin
        s = w00 * p00[16-8*k +: 8] + w10 * p10[16-8*k +: 8]
          + w01 * p01[16-8*k +: 8] + w11 * p11[16-8*k +: 8];
        if (k == 0) px.red = bis_pkg::CH_W'(s >> 16);
        else if (k == 1) px.green = bis_pkg::CH_W'(s >> 16);
        else px.blue = bis_pkg::CH_W'(s >> 16);
      end
    end
    px.last = (row_ctr == oh - 1) && (col_ctr == ow - 1);
    col_ctr++;
    if (col_ctr >= ow) begin
      col_ctr = 0;
      row_ctr++;
      if (row_ctr >= oh) row_ctr = 0;
    end
    return px;
  endfunction

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

  // Compare every strobed pixel against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pixel %h %h %h last %b",
          out_red_out, out_green_out, out_blue_out, out_frame_last);
      end else begin
        pixel_t want;
        want = pending_pixels.pop_front();
        if (want !== {out_red_out, out_green_out, out_blue_out, out_frame_last}) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pixel mismatch: exp %h %h %h last %b, got %h %h %h last %b",
              want.red, want.green, want.blue, want.last,
              out_red_out, out_green_out, out_blue_out, out_frame_last);
        end
      end
    end
  end

  // Drop start and hold until the block is quiet with nothing outstanding.
  task automatic settle();
    @(negedge clk) start <= 0;
    while (pending_pixels.size() != 0 || busy) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic [bis_pkg::CFG_IDX_W-1:0] idx,
                           logic [bis_pkg::CFG_DAT_W-1:0] d);
    @(negedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= d;
    @(negedge clk) cfg_we <= 0;
    shadow_write_reg(idx, d);
  endtask

  // Present one command and hold it until the transfer; return the predicted pixel of a request.
  task automatic send_cmd(logic op, logic [bis_pkg::CH_W-1:0] r, g, b, output pixel_t px);
    @(negedge clk);
    start <= 1; in_opcode <= op; in_red_in <= r; in_green_in <= g; in_blue_in <= b;
    do @(posedge clk); while (busy);
    item_count++;
    if (op) begin
      px = blend_next_pixel();
      pending_pixels.push_back(px);
    end else begin
      store_source_pixel(r, g, b);
      px = '0;
    end
  endtask

  // Insert a random idle burst, none near the end of the run.
  task automatic maybe_idle();
    int n;
    if (item_count < CALM_ITEMS && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 17);
      @(negedge clk) start <= 0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic random_cmd(logic op);
    pixel_t px;
    send_cmd(op, bis_pkg::CH_W'($urandom), bis_pkg::CH_W'($urandom),
             bis_pkg::CH_W'($urandom), px);
    maybe_idle();
  endtask

  row_t rows[$];

  task automatic add_row(row_kind_t k, logic [bis_pkg::CH_W-1:0] r, g, b,
                         logic [bis_pkg::CFG_IDX_W-1:0] idx,
                         logic [bis_pkg::CFG_DAT_W-1:0] d,
                         bit typed, pixel_t want);
    row_t t;
    t.kind = k; t.r = r; t.g = g; t.b = b; t.idx = idx; t.data = d;
    t.typed = typed; t.want = want;
    rows.push_back(t);
  endtask

  initial begin
    pixel_t got, white_last, none;
    int unsigned wv, hv, ew, eh, owv, ohv, invv, nreq, mode;
    white_last = {bis_pkg::WHITE_LEVEL, bis_pkg::WHITE_LEVEL, bis_pkg::WHITE_LEVEL, 1'b1};
    none = '0;
    mismatches = 0; item_count = 0;
    rst_n = 0; start = 0; in_opcode = 0;
    in_red_in = 0; in_green_in = 0; in_blue_in = 0;
    cfg_we = 0; cfg_index = 0; cfg_wdata = 0;
    load_ptr = 0; row_ctr = 0; col_ctr = 0;
    reg_src_w = 1; reg_src_h = 1; reg_out_w = 1; reg_out_h = 1;
    reg_inv = 256; reg_flip = 0;
    repeat (8) @(negedge clk);
    rst_n = 1;

    // After reset a 1x1 image has no 2x2 window, so every request is white.
    add_row(ROW_LOAD, 8'h00, 8'h00, 8'h00, 0, 0, 0, none);
    add_row(ROW_REQ, 0, 0, 0, 0, 0, 1, white_last);
    add_row(ROW_LOAD, 8'hFF, 8'hFF, 8'hFF, 0, 0, 0, none);
    add_row(ROW_REQ, 0, 0, 0, 0, 0, 1, white_last);
    add_row(ROW_CFG, 0, 0, 0, bis_pkg::CFG_SRC_WIDTH, 2, 0, none);
    add_row(ROW_CFG, 0, 0, 0, bis_pkg::CFG_SRC_HEIGHT, 2, 0, none);
    add_row(ROW_CFG, 0, 0, 0, bis_pkg::CFG_OUT_WIDTH, 4, 0, none);
    add_row(ROW_CFG, 0, 0, 0, bis_pkg::CFG_OUT_HEIGHT, 4, 0, none);
    add_row(ROW_CFG, 0, 0, 0, bis_pkg::CFG_INV_SCALE, 128, 0, none);
    add_row(ROW_LOAD, 8'hFF, 8'h00, 8'h00, 0, 0, 0, none);
    add_row(ROW_LOAD, 8'h00, 8'hFF, 8'h00, 0, 0, 0, none);
    add_row(ROW_LOAD, 8'h00, 8'h00, 8'hFF, 0, 0, 0, none);
    add_row(ROW_LOAD, 8'hFF, 8'hFF, 8'hFF, 0, 0, 0, none);
    for (int i = 0; i < 5; i++) add_row(ROW_REQ, 0, 0, 0, 0, 0, 0, none);
    add_row(ROW_CFG, 0, 0, 0, bis_pkg::CFG_FLIP_ROWS, 1, 0, none);
    add_row(ROW_CFG, 0, 0, 0, CFG_SPARE_A, 16'hFFFF, 0, none);
    add_row(ROW_CFG, 0, 0, 0, CFG_SPARE_B, 16'h0000, 0, none);
    for (int i = 0; i < 4; i++) add_row(ROW_REQ, 0, 0, 0, 0, 0, 0, none);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        settle();
        write_reg(rows[i].idx, rows[i].data);
      end else begin
        send_cmd(rows[i].kind == ROW_REQ, rows[i].r, rows[i].g, rows[i].b, got);
        if (rows[i].typed && got !== rows[i].want) begin
          mismatches++;
          if (mismatches <= 10) $display("directed row %0d: predictor %h, table %h",
            i, got, rows[i].want);
        end
      end
    end

    // Random phases: reprogram, fill the whole image, then mostly requests.
    while (item_count < TARGET_ITEMS) begin
      settle();
      mode = $urandom_range(0, 9);
      case (mode)
        0: begin wv = 9'h1FF; hv = 1; end
        1: begin wv = 1; hv = 256; end
        2: begin wv = 0; hv = $urandom_range(1, 4); end
        3: begin wv = 256; hv = 0; end
        default: begin wv = $urandom_range(1, 8); hv = $urandom_range(1, 8); end
      endcase
      ew = clamp_size(wv, 256); eh = clamp_size(hv, 256);
      case ($urandom_range(0, 7))
        0: owv = 1024;
        1: owv = 16'hF7FF;
        2: owv = 0;
        default: owv = $urandom_range(1, 24);
      endcase
      ohv = ($urandom_range(0, 7) == 0) ? 1024 : $urandom_range(1, 12);
      case ($urandom_range(0, 7))
        0: invv = $urandom_range(1, 65535);
        1: invv = 0;
        2: invv = 65535;
        default: invv = (ew * 256) / clamp_size(owv & 16'h07FF, 1024)
                        + $urandom_range(0, 40);
      endcase
      write_reg(bis_pkg::CFG_SRC_WIDTH,
                bis_pkg::CFG_DAT_W'((mode == 0) ? 16'hFFFF : wv));
      write_reg(bis_pkg::CFG_SRC_HEIGHT, bis_pkg::CFG_DAT_W'(hv));
      write_reg(bis_pkg::CFG_OUT_WIDTH, bis_pkg::CFG_DAT_W'(owv));
      write_reg(bis_pkg::CFG_OUT_HEIGHT, bis_pkg::CFG_DAT_W'(ohv));
      write_reg(bis_pkg::CFG_INV_SCALE, bis_pkg::CFG_DAT_W'(invv));
      write_reg(bis_pkg::CFG_FLIP_ROWS, $urandom_range(0, 1) ? 16'hFFFF : 16'hFFFE);
      for (int unsigned i = 0; i < ew * eh; i++) random_cmd(0);
      nreq = $urandom_range(8, 40);
      for (int unsigned i = 0; i < nreq; i++)
        random_cmd($urandom_range(0, 9) != 0);
    end

    settle();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
